// File: hdl/assert_macros.svh
// assertion macros for the port-level checker hcbp_checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define HCBP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define HCBP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/hcbp_pkg.sv
// shared types and constants for the huffman code bit packer
`timescale 1ns / 1ps

package hcbp_pkg;

  localparam int CMD_W  = 2;
  localparam int SYM_W  = 8;
  localparam int CODE_W = 24;
  localparam int LEN_W  = 5;
  localparam int KIND_W = 2;
  localparam int BYTE_W = 8;
  localparam int PAD_W  = 3;
  localparam int PEND_W = 7;
  localparam int CNT_W  = 3;

  localparam int DEF_MAX_CODE_LEN  = 24;
  localparam int DEF_ALPHABET_SIZE = 256;

  localparam int Q_DEPTH = 4;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD   = 2'd0,
    CMD_ENCODE = 2'd1,
    CMD_FLUSH  = 2'd2
  } cmd_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_DATA = 2'd0,
    KIND_END  = 2'd1,
    KIND_ERR  = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    OP_ENCODE = 2'd0,
    OP_ERROR  = 2'd1,
    OP_FLUSH  = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    BK_IDLE  = 2'd0,
    BK_BYTES = 2'd1,
    BK_END   = 2'd2
  } back_state_t;

  typedef struct packed {
    op_t               op;
    logic [CODE_W-1:0] code;
    logic [LEN_W-1:0]  len;
  } q_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

// File: hdl/hcbp_queue.sv
// short fifo of classified items between front and back end
`timescale 1ns / 1ps

module hcbp_queue import hcbp_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push_valid,
  input  q_entry_t  push_entry,
  input  logic      pop,
  output q_entry_t  head,
  output q_status_t stat
);

  localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;

  q_entry_t         mem_r [Q_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [PTR_W:0]   cnt_r, cnt_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push_valid) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push_valid && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!push_valid && pop) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_valid) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

  assign head       = mem_r[rd_ptr_r];
  assign stat.full  = (cnt_r == (PTR_W+1)'(Q_DEPTH));
  assign stat.empty = (cnt_r == '0);

endmodule

// File: hdl/hcbp_front.sv
// front end: takes items, keeps the code table, classifies encode and flush
`timescale 1ns / 1ps

module hcbp_front import hcbp_pkg::*; #(
  parameter int MAX_CODE_LEN  = DEF_MAX_CODE_LEN,
  parameter int ALPHABET_SIZE = DEF_ALPHABET_SIZE
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [CMD_W-1:0]  in_command,
  input  logic [SYM_W-1:0]  in_symbol,
  input  logic [CODE_W-1:0] in_code_value,
  input  logic [LEN_W-1:0]  in_code_length,
  output logic              push_valid,
  output q_entry_t          push_entry,
  input  q_status_t         q_stat
);

  localparam int IDX_W = (ALPHABET_SIZE > 1) ? $clog2(ALPHABET_SIZE) : 1;
  localparam logic [SYM_W:0] SYM_LIM = (SYM_W+1)'(ALPHABET_SIZE);
  localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_CODE_LEN);

  logic [CODE_W-1:0]        code_mem [ALPHABET_SIZE];
  logic [LEN_W-1:0]         len_mem  [ALPHABET_SIZE];
  logic [ALPHABET_SIZE-1:0] valid_r, valid_nxt;

  logic              accept;
  logic              in_range;
  logic [IDX_W-1:0]  idx;
  logic [LEN_W-1:0]  len_sat;
  logic              do_load;
  logic              do_read;
  logic              take_s1;
  op_t               op_new;

  logic              s1_valid_r, s1_valid_nxt;
  op_t               s1_op_r;
  logic [CODE_W-1:0] rd_code_r;
  logic [LEN_W-1:0]  rd_len_r;
  logic [CODE_W-1:0] code_masked;

  assign accept   = in_valid && in_ready;
  assign in_range = ({1'b0, in_symbol} < SYM_LIM);
  assign idx      = in_symbol[IDX_W-1:0];
  assign len_sat  = (in_code_length > LEN_MAX) ? LEN_MAX : in_code_length;

  // command decode
  always_comb begin
    do_load = 1'b0;
    do_read = 1'b0;
    take_s1 = 1'b0;
    op_new  = OP_FLUSH;
    unique case (in_command)
      CMD_LOAD: begin
        do_load = accept && in_range;
      end
      CMD_ENCODE: begin
        do_read = accept && in_range;
        take_s1 = accept;
        op_new  = (in_range && valid_r[idx]) ? OP_ENCODE : OP_ERROR;
      end
      CMD_FLUSH: begin
        take_s1 = accept;
        op_new  = OP_FLUSH;
      end
      default: begin
        take_s1 = 1'b0;
      end
    endcase
  end

  always_comb begin
    valid_nxt = valid_r;
    if (do_load) begin
      valid_nxt[idx] = (in_code_length != '0);
    end
  end

  always_ff @(posedge clk) begin
    if (do_load && (in_code_length != '0)) begin
      code_mem[idx] <= in_code_value;
      len_mem[idx]  <= len_sat;
    end
    if (do_read) begin
      rd_code_r <= code_mem[idx];
      rd_len_r  <= len_mem[idx];
    end
  end

  assign push_valid = s1_valid_r && !q_stat.full;
  assign in_ready   = !s1_valid_r || !q_stat.full;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (take_s1) begin
      s1_valid_nxt = 1'b1;
    end else if (push_valid) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      valid_r    <= valid_nxt;
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take_s1) begin
      s1_op_r <= op_new;
    end
  end

  // keep only the low len bits of the stored code
  always_comb begin
    for (int i = 0; i < CODE_W; i++) begin
      code_masked[i] = rd_code_r[i] && (i < int'(rd_len_r));
    end
  end

  assign push_entry.op   = s1_op_r;
  assign push_entry.code = code_masked;
  assign push_entry.len  = rd_len_r;

endmodule

// File: hdl/hcbp_back.sv
// back end: bit buffer, byte packing, flush, error reports and result register
`timescale 1ns / 1ps

module hcbp_back import hcbp_pkg::*; #(
  parameter int MAX_CODE_LEN = DEF_MAX_CODE_LEN
) (
  input  logic              clk,
  input  logic              rst_n,
  input  q_entry_t          head,
  input  q_status_t         q_stat,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [KIND_W-1:0] out_kind,
  output logic [BYTE_W-1:0] out_byte,
  output logic [PAD_W-1:0]  out_pad_bits,
  output logic              out_last
);

  localparam int ACC_W = MAX_CODE_LEN + PEND_W;
  localparam int TOT_W = $clog2(ACC_W + 1);
  localparam logic [TOT_W-1:0] TOT_BYTE = TOT_W'(BYTE_W);

  back_state_t       state_r, state_nxt;
  logic [ACC_W-1:0]  acc_r, acc_nxt;
  logic [TOT_W-1:0]  tot_r, tot_nxt;
  logic [PAD_W-1:0]  pad_r, pad_nxt;
  logic [PEND_W-1:0] pend_bits_r, pend_bits_nxt;
  logic [CNT_W-1:0]  pend_cnt_r, pend_cnt_nxt;

  logic              out_valid_r;
  kind_t             out_kind_r;
  logic [BYTE_W-1:0] out_byte_r;
  logic [PAD_W-1:0]  out_pad_r;
  logic              out_last_r;

  logic              can_emit;
  logic [ACC_W-1:0]  acc_new;
  logic [TOT_W-1:0]  tot_new;
  logic [ACC_W-1:0]  src_acc;
  logic [TOT_W-1:0]  src_tot;
  logic [TOT_W-1:0]  rem;
  logic [BYTE_W-1:0] byte_x;
  logic              have_byte;
  logic              rem_more;
  logic [PEND_W-1:0] keep_mask;
  logic [PAD_W-1:0]  flush_pad;
  logic [BYTE_W-1:0] flush_byte;

  logic              emit;
  kind_t             e_kind;
  logic [BYTE_W-1:0] e_byte;
  logic [PAD_W-1:0]  e_pad;
  logic              e_last;

  assign can_emit = !out_valid_r || out_ready;
  assign pop      = (state_r == BK_IDLE) && !q_stat.empty && can_emit;

  // append new code below the pending bits
  assign acc_new = (ACC_W'(pend_bits_r) << head.len) | ACC_W'(head.code);
  assign tot_new = TOT_W'(pend_cnt_r) + TOT_W'(head.len);

  assign src_acc   = (state_r == BK_BYTES) ? acc_r : acc_new;
  assign src_tot   = (state_r == BK_BYTES) ? tot_r : tot_new;
  assign rem       = src_tot - TOT_BYTE;
  assign byte_x    = BYTE_W'(src_acc >> rem);
  assign have_byte = (src_tot >= TOT_BYTE);
  assign rem_more  = (rem >= TOT_BYTE);

  assign keep_mask  = PEND_W'((8'd1 << tot_new[CNT_W-1:0]) - 8'd1);
  assign flush_pad  = PAD_W'(4'd8 - {1'b0, pend_cnt_r});
  assign flush_byte = BYTE_W'({1'b0, pend_bits_r} << flush_pad);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_IDLE: begin
        if (pop) begin
          case (head.op)
            OP_ENCODE: state_nxt = (have_byte && rem_more) ? BK_BYTES : BK_IDLE;
            OP_FLUSH:  state_nxt = (pend_cnt_r != '0) ? BK_END : BK_IDLE;
            default:   state_nxt = BK_IDLE;
          endcase
        end
      end
      BK_BYTES: begin
        if (can_emit && !rem_more) begin
          state_nxt = BK_IDLE;
        end
      end
      BK_END: begin
        if (can_emit) begin
          state_nxt = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  // results and buffer updates
  always_comb begin
    emit          = 1'b0;
    e_kind        = KIND_DATA;
    e_byte        = '0;
    e_pad         = '0;
    e_last        = 1'b0;
    acc_nxt       = acc_r;
    tot_nxt       = tot_r;
    pad_nxt       = pad_r;
    pend_bits_nxt = pend_bits_r;
    pend_cnt_nxt  = pend_cnt_r;
    unique case (state_r)
      BK_IDLE: begin
        if (pop) begin
          case (head.op)
            OP_ENCODE: begin
              pend_cnt_nxt  = tot_new[CNT_W-1:0];
              pend_bits_nxt = acc_new[PEND_W-1:0] & keep_mask;
              acc_nxt       = acc_new;
              tot_nxt       = rem;
              if (have_byte) begin
                emit   = 1'b1;
                e_byte = byte_x;
                e_last = !rem_more;
              end
            end
            OP_FLUSH: begin
              pend_bits_nxt = '0;
              pend_cnt_nxt  = '0;
              emit          = 1'b1;
              if (pend_cnt_r != '0) begin
                e_byte  = flush_byte;
                pad_nxt = flush_pad;
              end else begin
                e_kind = KIND_END;
                e_last = 1'b1;
              end
            end
            default: begin
              emit   = 1'b1;
              e_kind = KIND_ERR;
              e_last = 1'b1;
            end
          endcase
        end
      end
      BK_BYTES: begin
        if (can_emit) begin
          emit    = 1'b1;
          e_byte  = byte_x;
          e_last  = !rem_more;
          tot_nxt = rem;
        end
      end
      BK_END: begin
        if (can_emit) begin
          emit   = 1'b1;
          e_kind = KIND_END;
          e_pad  = pad_r;
          e_last = 1'b1;
        end
      end
      default: emit = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      pend_bits_r <= '0;
      pend_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pend_bits_r <= pend_bits_nxt;
      pend_cnt_r  <= pend_cnt_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    tot_r <= tot_nxt;
    pad_r <= pad_nxt;
    if (emit) begin
      out_kind_r <= e_kind;
      out_byte_r <= e_byte;
      out_pad_r  <= e_pad;
      out_last_r <= e_last;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_kind     = out_kind_r;
  assign out_byte     = out_byte_r;
  assign out_pad_bits = out_pad_r;
  assign out_last     = out_last_r;

endmodule

// File: hdl/huffman_code_bit_packer.sv
// path: an accepted item passes the front end register and the queue into the result register
// throughput: one item per cycle while the queue has room; the back end sends one result per
// cycle while out_ready is high; a multi-byte encode or a partial-byte flush keeps it busy
// reset: valid bits, bit buffer, queue and result register clear;
// code table contents are kept, entries count only after a load
// top level: front end, 4-entry queue, back end
`timescale 1ns / 1ps

module huffman_code_bit_packer import hcbp_pkg::*; #(
  parameter int MAX_CODE_LEN  = DEF_MAX_CODE_LEN,
  parameter int ALPHABET_SIZE = DEF_ALPHABET_SIZE
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [CMD_W-1:0]  in_command,
  input  logic [SYM_W-1:0]  in_symbol,
  input  logic [CODE_W-1:0] in_code_value,
  input  logic [LEN_W-1:0]  in_code_length,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [KIND_W-1:0] out_kind,
  output logic [BYTE_W-1:0] out_byte,
  output logic [PAD_W-1:0]  out_pad_bits,
  output logic              out_last
);

  logic      push_valid;
  q_entry_t  push_entry;
  q_entry_t  head;
  q_status_t q_stat;
  logic      pop;

  hcbp_front #(
    .MAX_CODE_LEN  (MAX_CODE_LEN),
    .ALPHABET_SIZE (ALPHABET_SIZE)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_command     (in_command),
    .in_symbol      (in_symbol),
    .in_code_value  (in_code_value),
    .in_code_length (in_code_length),
    .push_valid     (push_valid),
    .push_entry     (push_entry),
    .q_stat         (q_stat)
  );

  hcbp_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .stat       (q_stat)
  );

  hcbp_back #(
    .MAX_CODE_LEN (MAX_CODE_LEN)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .head         (head),
    .q_stat       (q_stat),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_kind     (out_kind),
    .out_byte     (out_byte),
    .out_pad_bits (out_pad_bits),
    .out_last     (out_last)
  );

endmodule

// File: hdl/hcbp_checker.sv
// port-level checks for the huffman code bit packer, bound to the top level
`timescale 1ns / 1ps
`include "assert_macros.svh"

module hcbp_checker import hcbp_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_ready,
  input logic [KIND_W-1:0] out_kind,
  input logic [BYTE_W-1:0] out_byte,
  input logic [PAD_W-1:0]  out_pad_bits,
  input logic              out_last
);

  // an error result stands alone
  `HCBP_ASSERT_IMP(a_err_last, out_valid && (out_kind == KIND_ERR), out_last, "error not last")
  // the end report closes a flush
  `HCBP_ASSERT_IMP(a_end_last, out_valid && (out_kind == KIND_END), out_last, "end not last")
  // data bytes and errors carry no pad count
  `HCBP_ASSERT_IMP(a_pad_zero, out_valid && (out_kind != KIND_END), out_pad_bits == '0,
    "pad bits outside end report")
  // a stalled result holds
  `HCBP_ASSERT_NXT(a_out_hold, out_valid && !out_ready,
    out_valid && $stable(out_kind) && $stable(out_byte) && $stable(out_last), "result changed")

endmodule

bind huffman_code_bit_packer hcbp_checker u_hcbp_checker (.*);

// File: bench/packer_checker.sv
// checker for the huffman code bit packer: predicts packed bytes and compares results
`timescale 1ns / 1ps

module packer_checker import hcbp_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_ready,
  input  logic [CMD_W-1:0]  in_command,
  input  logic [SYM_W-1:0]  in_symbol,
  input  logic [CODE_W-1:0] in_code_value,
  input  logic [LEN_W-1:0]  in_code_length,
  input  logic              out_valid,
  input  logic              out_ready,
  input  logic [KIND_W-1:0] out_kind,
  input  logic [BYTE_W-1:0] out_byte,
  input  logic [PAD_W-1:0]  out_pad_bits,
  input  logic              out_last,
  output int                mismatch_count,
  output int                results_owed
);

  localparam int MAX_LEN  = DEF_MAX_CODE_LEN;
  localparam int ALPHABET = DEF_ALPHABET_SIZE;
  localparam int REPORT_MAX = 10;

  typedef struct packed {
    kind_t             kind;
    logic [BYTE_W-1:0] data;
    logic [PAD_W-1:0]  pad;
    logic              last;
  } packed_result_t;

  packed_result_t    owed_q[$];
  logic [CODE_W-1:0] code_tab [ALPHABET];
  logic [LEN_W-1:0]  len_tab  [ALPHABET];
  logic              live_tab [ALPHABET];
  logic [PEND_W-1:0] buf_bits;
  logic [CNT_W-1:0]  buf_cnt;

  function automatic void owe(kind_t k, logic [BYTE_W-1:0] d, logic [PAD_W-1:0] p, logic l);
    packed_result_t r;
    r.kind = k;
    r.data = d;
    r.pad  = p;
    r.last = l;
    owed_q.push_back(r);
  endfunction

  function automatic void pack_item(logic [CMD_W-1:0] cmd, logic [SYM_W-1:0] sym,
                                    logic [CODE_W-1:0] val, logic [LEN_W-1:0] len);
    logic [63:0] acc;
    int total;
    int n;
    int width;
    logic [PAD_W-1:0] pad;
    n = 0;
    case (cmd)
      CMD_LOAD: begin
        if (int'(sym) < ALPHABET) begin
          if (len == '0) begin
            live_tab[sym] = 1'b0;
          end else begin
            code_tab[sym] = val;
            len_tab[sym]  = (int'(len) > MAX_LEN) ? LEN_W'(MAX_LEN) : len;
            live_tab[sym] = 1'b1;
          end
        end
      end
      CMD_ENCODE: begin
        if (int'(sym) >= ALPHABET || !live_tab[sym]) begin
          owe(KIND_ERR, '0, '0, 1'b1);
        end else begin
          width = int'(len_tab[sym]);
          acc = (64'(buf_bits) << width) | (64'(code_tab[sym]) & ((64'd1 << width) - 64'd1));
          total = int'(buf_cnt) + width;
          // a long code can complete up to three bytes at once
          while (total >= 8 && n < 4) begin
            total -= 8;
            owe(KIND_DATA, BYTE_W'(acc >> total), '0, 1'b0);
            n++;
          end
          if (n > 0) begin
            owed_q[owed_q.size()-1].last = 1'b1;
          end
          buf_cnt  = CNT_W'(total);
          buf_bits = PEND_W'(acc & ((64'd1 << buf_cnt) - 64'd1));
        end
      end
      CMD_FLUSH: begin
        pad = '0;
        if (buf_cnt != '0) begin
          pad = PAD_W'(8 - int'(buf_cnt));
          owe(KIND_DATA, BYTE_W'(16'(buf_bits) << pad), '0, 1'b0);
        end
        owe(KIND_END, '0, pad, 1'b1);
        buf_bits = '0;
        buf_cnt  = '0;
      end
      default: ;
    endcase
  endfunction

  always @(posedge clk) begin : watch
    packed_result_t want;
    if (!rst_n) begin
      for (int i = 0; i < ALPHABET; i++) begin
        live_tab[i] = 1'b0;
      end
      buf_bits = '0;
      buf_cnt  = '0;
      owed_q.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (owed_q.size() == 0) begin
          if (mismatch_count < REPORT_MAX) begin
            $display("%0t: unexpected result kind %0d byte %02h pad %0d last %0b",
                     $realtime, out_kind, out_byte, out_pad_bits, out_last);
          end
          mismatch_count++;
        end else begin
          want = owed_q.pop_front();
          if (out_kind !== want.kind || out_byte !== want.data ||
              out_pad_bits !== want.pad || out_last !== want.last) begin
            if (mismatch_count < REPORT_MAX) begin
              $display("%0t: mismatch, expected kind %0d byte %02h pad %0d last %0b, got kind %0d byte %02h pad %0d last %0b",
                       $realtime, want.kind, want.data, want.pad, want.last,
                       out_kind, out_byte, out_pad_bits, out_last);
            end
            mismatch_count++;
          end
        end
      end
      if (in_valid && in_ready) begin
        pack_item(in_command, in_symbol, in_code_value, in_code_length);
      end
    end
    results_owed = owed_q.size();
  end

endmodule

// File: bench/tb_top.sv
// top of the huffman code bit packer testbench: clock, reset, stimulus and verdict
`timescale 1ns / 1ps

module tb_top;
  import hcbp_pkg::*;

  localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;
  localparam int RUN_ITEMS    = 210;
  localparam int CALM_ITEMS   = 40;
  localparam int DRAIN_CYCLES = 16;
  localparam int CYCLE_LIMIT  = 200000;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  logic [CMD_W-1:0]  in_command;
  logic [SYM_W-1:0]  in_symbol;
  logic [CODE_W-1:0] in_code_value;
  logic [LEN_W-1:0]  in_code_length;
  logic              out_valid;
  logic              out_ready;
  logic [KIND_W-1:0] out_kind;
  logic [BYTE_W-1:0] out_byte;
  logic [PAD_W-1:0]  out_pad_bits;
  logic              out_last;

  int   mismatch_count;
  int   results_owed;
  int   cycles;
  logic calm;
  logic [SYM_W-1:0] coded_syms[$];

  huffman_code_bit_packer dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_command     (in_command),
    .in_symbol      (in_symbol),
    .in_code_value  (in_code_value),
    .in_code_length (in_code_length),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_kind       (out_kind),
    .out_byte       (out_byte),
    .out_pad_bits   (out_pad_bits),
    .out_last       (out_last)
  );

  packer_checker chk (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_command     (in_command),
    .in_symbol      (in_symbol),
    .in_code_value  (in_code_value),
    .in_code_length (in_code_length),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_kind       (out_kind),
    .out_byte       (out_byte),
    .out_pad_bits   (out_pad_bits),
    .out_last       (out_last),
    .mismatch_count (mismatch_count),
    .results_owed   (results_owed)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("tb: failure");
    $finish;
  end

  // receiver stalls in random bursts, always ready once the run goes calm
  initial begin
    forever begin
      if (calm || $urandom_range(0, 2) != 0) begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end else begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
  end

  task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [SYM_W-1:0] sym,
                           input logic [CODE_W-1:0] val, input logic [LEN_W-1:0] len);
    logic took;
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_command     <= cmd;
    in_symbol      <= sym;
    in_code_value  <= val;
    in_code_length <= len;
    // ready is sampled mid-cycle, where it is stable up to the next edge
    do begin
      @(negedge clk);
      took = in_ready;
      @(posedge clk);
    end while (!took);
  endtask

  initial begin : stimulus
    int roll;
    int pick;
    logic [SYM_W-1:0]  sym;
    logic [CODE_W-1:0] val;
    logic [LEN_W-1:0]  len;

    calm           = 1'b0;
    rst_n          <= 1'b0;
    in_valid       <= 1'b0;
    in_command     <= CMD_LOAD;
    in_symbol      <= '0;
    in_code_value  <= '0;
    in_code_length <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty flush, absent symbol, then table edges and multi-byte codes
    send_item(CMD_FLUSH, 8'd0, 24'd0, 5'd0);
    send_item(CMD_ENCODE, 8'd0, 24'd0, 5'd0);
    send_item(CMD_LOAD, 8'd0, 24'hFFFFFF, 5'd24);
    send_item(CMD_LOAD, 8'd255, 24'h000000, 5'd1);
    send_item(CMD_LOAD, 8'd17, 24'hABCDEF, 5'd3);
    send_item(CMD_LOAD, 8'd200, 24'h123456, 5'd31);
    send_item(CMD_LOAD, 8'd128, 24'h000055, 5'd7);
    send_item(CMD_ENCODE, 8'd255, 24'hFFFFFF, 5'd31);
    send_item(CMD_ENCODE, 8'd0, 24'd0, 5'd0);
    send_item(CMD_ENCODE, 8'd17, 24'd0, 5'd0);
    send_item(CMD_ENCODE, 8'd200, 24'd0, 5'd0);
    send_item(CMD_SPARE, 8'hFF, 24'hFFFFFF, 5'h1F);
    send_item(CMD_FLUSH, 8'hFF, 24'hFFFFFF, 5'h1F);
    send_item(CMD_LOAD, 8'd255, 24'hFFFFFF, 5'd0);
    send_item(CMD_ENCODE, 8'd255, 24'd0, 5'd0);
    send_item(CMD_ENCODE, 8'd17, 24'd0, 5'd0);
    send_item(CMD_FLUSH, 8'd0, 24'd0, 5'd0);
    send_item(CMD_ENCODE, 8'd128, 24'd0, 5'd0);
    send_item(CMD_ENCODE, 8'd128, 24'd0, 5'd0);
    send_item(CMD_FLUSH, 8'd0, 24'd0, 5'd0);
    send_item(CMD_FLUSH, 8'd0, 24'd0, 5'd0);
    coded_syms = '{8'd0, 8'd17, 8'd200, 8'd128};

    for (int i = 0; i < RUN_ITEMS; i++) begin
      calm = (i >= RUN_ITEMS - CALM_ITEMS);
      roll = $urandom_range(0, 99);
      sym  = SYM_W'($urandom_range(0, 255));
      val  = CODE_W'($urandom);
      len  = LEN_W'($urandom_range(0, 31));
      if (roll < 14) begin
        pick = $urandom_range(0, 19);
        if (pick == 0) begin
          len = '0;
        end else if (pick == 1) begin
          len = LEN_W'($urandom_range(25, 31));
        end else if (pick < 5) begin
          len = LEN_W'($urandom_range(10, 24));
        end else begin
          len = LEN_W'($urandom_range(1, 9));
        end
        if (len != '0) begin
          coded_syms.push_back(sym);
        end
        send_item(CMD_LOAD, sym, val, len);
      end else if (roll < 84) begin
        // mostly symbols with a table entry, now and then a stray one
        if ($urandom_range(0, 9) != 0) begin
          sym = coded_syms[$urandom_range(0, coded_syms.size() - 1)];
        end
        send_item(CMD_ENCODE, sym, val, len);
      end else if (roll < 95) begin
        send_item(CMD_FLUSH, sym, val, len);
      end else begin
        send_item(CMD_SPARE, sym, val, len);
      end
    end
    in_valid <= 1'b0;

    do @(negedge clk); while (results_owed != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
